### hw/rtl/quaternion_to_euler_angles_macros.svh
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_macros
// Assertion helpers for the checker file.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_ANGLES_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define QTE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define QTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Shared widths, constants and helper functions for the quaternion to Euler
// angle converter.
// ----------------------------------------------------------------------------
`default_nettype none

package qte_pkg;

    // Defaults for the top-level parameters.
    localparam int CORDIC_STEPS_DEF   = 16;
    localparam int QUAT_FRAC_BITS_DEF = 14;

    // Width of the five sums of products (fixed by the 16-bit components).
    localparam int SUM_W  = 35;
    // CORDIC datapath width, with headroom for gain and pre-rotation.
    localparam int COR_W  = 38;
    // Angle accumulator width, units of 2^-16 degree.
    localparam int ANG_W  = 26;
    // Width of the rounded and clamped angle, before the cut to the port width.
    localparam int RND_W  = 14;
    localparam int ATAN_TAB_LEN = 24;

    localparam int ROLL_LIM  = 2880;
    localparam int PITCH_LIM = 1440;
    localparam int ANG_90    = 90 * 65536;

    typedef logic signed [SUM_W-1:0] t_sum;
    typedef logic signed [ANG_W-1:0] t_ang;

    // atan(2^-i) in 2^-16 degree, rounded to nearest.
    function automatic t_ang atan_entry(input int idx);
        t_ang v;
        case (idx)
            0:  v = t_ang'(2949120);
            1:  v = t_ang'(1740967);
            2:  v = t_ang'(919879);
            3:  v = t_ang'(466945);
            4:  v = t_ang'(234379);
            5:  v = t_ang'(117304);
            6:  v = t_ang'(58666);
            7:  v = t_ang'(29335);
            8:  v = t_ang'(14668);
            9:  v = t_ang'(7334);
            10: v = t_ang'(3667);
            11: v = t_ang'(1833);
            12: v = t_ang'(917);
            13: v = t_ang'(458);
            14: v = t_ang'(229);
            15: v = t_ang'(115);
            16: v = t_ang'(57);
            17: v = t_ang'(29);
            18: v = t_ang'(14);
            19: v = t_ang'(7);
            20: v = t_ang'(4);
            21: v = t_ang'(2);
            22: v = t_ang'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    // Round an angle to sixteenths of a degree (floor of (a+2048)/4096)
    // and clamp it to plus or minus lim.
    function automatic logic signed [RND_W-1:0] round_clamp(input t_ang a,
                                                           input int lim);
        logic signed [ANG_W:0]   sum;
        logic signed [ANG_W-12:0] r;
        logic signed [RND_W-1:0] res;
        sum = {a[ANG_W-1], a} + (ANG_W+1)'(2048);
        r   = sum[ANG_W:12];
        if (r > (ANG_W-11)'(lim)) begin
            res = RND_W'(lim);
        end else if (r < -(ANG_W-11)'(lim)) begin
            res = -RND_W'(lim);
        end else begin
            res = r[RND_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/qte_cordic.sv
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined vectoring CORDIC: atan2(y, x) in 2^-16 degree, one stage per
// iteration after a pre-rotation stage that folds the left half plane.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_cordic #(
    parameter int STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_en,
    input  wire logic signed [qte_pkg::COR_W-1:0]  i_y,
    input  wire logic signed [qte_pkg::COR_W-1:0]  i_x,
    output logic signed      [qte_pkg::ANG_W-1:0]  o_ang
);
    import qte_pkg::*;

    logic signed [COR_W-1:0] r_x    [0:STEPS];
    logic signed [COR_W-1:0] r_y    [0:STEPS];
    t_ang                    r_z    [0:STEPS];
    logic                    r_zero [0:STEPS];

    // Pre-rotation: bring the vector into the right half plane.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (i_x < 0 && i_y >= 0) begin
                r_x[0] <= i_y;
                r_y[0] <= -i_x;
                r_z[0] <= t_ang'(ANG_90);
            end else if (i_x < 0) begin
                r_x[0] <= -i_y;
                r_y[0] <= i_x;
                r_z[0] <= -t_ang'(ANG_90);
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_z[0] <= '0;
            end
        end
    end

    // One micro-rotation per stage, driving y toward zero.
    for (genvar g = 0; g < STEPS; g++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[g+1] <= r_zero[g];
                if (r_y[g] >= 0) begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + atan_entry(g);
                end else begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - atan_entry(g);
                end
            end
        end
    end

    // A null vector has angle zero.
    assign o_ang = r_zero[STEPS] ? '0 : r_z[STEPS];

endmodule

`default_nettype wire

### hw/rtl/quaternion_to_euler_angles.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Converts one fixed-point quaternion to roll, pitch and yaw per cycle while no result is held.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (i_valid, o_stall) carries the four components w, x,
// y, z as signed values with QUAT_FRAC_BITS fraction bits. The result
// channel (o_valid, i_stall) returns roll, pitch and yaw in sixteenths of a
// degree plus a flag set when the pitch term reached magnitude one.
// A request passes through the product, sum, magnitude and radicand stages,
// one stage per root bit of the pitch square root, the pre-rotation and
// CORDIC_STEPS iterations of the three CORDIC pipelines, and the output
// register.
// Throughput is one request per cycle while no result is held on i_stall; results come out in order.
// While a result waits on i_stall the whole pipeline holds and o_stall is
// raised; nothing is dropped or repeated. When the output is empty the
// pipeline keeps moving whatever i_stall does.
// Reset clears every valid bit; data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_to_euler_angles #(
    parameter int CORDIC_STEPS   = qte_pkg::CORDIC_STEPS_DEF,
    parameter int QUAT_FRAC_BITS = qte_pkg::QUAT_FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [15:0] i_quat_w,
    input  wire logic signed [15:0] i_quat_x,
    input  wire logic signed [15:0] i_quat_y,
    input  wire logic signed [15:0] i_quat_z,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [12:0]      o_roll_angle,
    output logic signed [11:0]      o_pitch_angle,
    output logic signed [12:0]      o_yaw_angle,
    output logic                    o_pitch_saturated
);
    import qte_pkg::*;

    localparam int F        = QUAT_FRAC_BITS;
    localparam int MAG_W    = 2 * F;
    localparam int RT_W     = 2 * F + 1;
    localparam int REM_W    = RT_W + 2;
    localparam int RAD_W    = 4 * F + 2;
    localparam int SQ_STEPS = RT_W;
    localparam int LAT      = 5 + SQ_STEPS + CORDIC_STEPS + 2;
    localparam t_sum ONE    = SUM_W'(1) << (2 * F);
    localparam logic [RAD_W-1:0] ONE_SQ = RAD_W'(1) << (4 * F);

    typedef struct packed {
        t_sum sr;
        t_sum cr;
        t_sum sy;
        t_sum cy;
        t_sum sp;
        logic sat;
    } t_side;

    logic w_adv;
    logic r_vld [0:LAT-1];

    // The pipeline moves unless a finished result is being held.
    assign w_adv   = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !w_adv;
    assign o_valid = r_vld[LAT-1];

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) r_vld[k] <= 1'b0;
        end else if (w_adv) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < LAT; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // Stage 1: component products.
    logic signed [31:0] r_wx, r_yz, r_xx, r_yy, r_wz, r_xy, r_zz, r_wy, r_zx;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_wx <= i_quat_w * i_quat_x;
            r_yz <= i_quat_y * i_quat_z;
            r_xx <= i_quat_x * i_quat_x;
            r_yy <= i_quat_y * i_quat_y;
            r_wz <= i_quat_w * i_quat_z;
            r_xy <= i_quat_x * i_quat_y;
            r_zz <= i_quat_z * i_quat_z;
            r_wy <= i_quat_w * i_quat_y;
            r_zx <= i_quat_z * i_quat_x;
        end
    end

    // Stage 2: the five sums of products.
    t_sum r_sr, r_cr, r_sy, r_cy, r_sp;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sr <= (SUM_W'(r_wx) + SUM_W'(r_yz)) <<< 1;
            r_cr <= ONE - ((SUM_W'(r_xx) + SUM_W'(r_yy)) <<< 1);
            r_sy <= (SUM_W'(r_wz) + SUM_W'(r_xy)) <<< 1;
            r_cy <= ONE - ((SUM_W'(r_yy) + SUM_W'(r_zz)) <<< 1);
            r_sp <= (SUM_W'(r_wy) - SUM_W'(r_zx)) <<< 1;
        end
    end

    // Stage 3: magnitude of the pitch term and the saturation test.
    t_sum             w_abs;
    logic [MAG_W-1:0] r_mag;
    t_side            r_side [0:SQ_STEPS+2];
    assign w_abs = (r_sp < 0) ? -r_sp : r_sp;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mag          <= w_abs[MAG_W-1:0];
            r_side[0].sr   <= r_sr;
            r_side[0].cr   <= r_cr;
            r_side[0].sy   <= r_sy;
            r_side[0].cy   <= r_cy;
            r_side[0].sp   <= r_sp;
            r_side[0].sat  <= (w_abs >= ONE);
        end
    end

    // Side data delay line, kept aligned with the square root.
    for (genvar g = 1; g <= SQ_STEPS + 2; g++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (w_adv) r_side[g] <= r_side[g-1];
        end
    end

    // Stages 4 and 5: radicand of the cosine of pitch, one minus mag squared.
    logic [2*MAG_W-1:0] r_sq;
    logic [RAD_W-1:0]   r_rad0;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sq   <= r_mag * r_mag;
            r_rad0 <= ONE_SQ - RAD_W'(r_sq);
        end
    end

    // Floor square root, one result bit per stage.
    logic [REM_W-1:0] r_rem  [1:SQ_STEPS-1];
    logic [RT_W-1:0]  r_root [1:SQ_STEPS];
    logic [RAD_W-1:0] r_rad  [1:SQ_STEPS-1];

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
        logic [REM_W-1:0] w_rem_in;
        logic [RT_W-1:0]  w_root_in;
        logic [RAD_W-1:0] w_rad_in;
        logic [REM_W+1:0] w_cur;
        logic [REM_W+1:0] w_trial;
        logic             w_ge;
        // The first stage starts from an empty remainder and root.
        if (g == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_rad_in  = r_rad0;
        end else begin : g_next
            assign w_rem_in  = r_rem[g];
            assign w_root_in = r_root[g];
            assign w_rad_in  = r_rad[g];
        end
        assign w_cur   = {w_rem_in, w_rad_in[RAD_W-1:RAD_W-2]};
        assign w_trial = (REM_W+2)'({w_root_in, 2'b01});
        assign w_ge    = (w_cur >= w_trial);
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_root[g+1] <= {w_root_in[RT_W-2:0], w_ge};
            end
        end
        // The last stage only needs to produce the root.
        if (g < SQ_STEPS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_rem[g+1] <= w_ge ? REM_W'(w_cur - w_trial) : REM_W'(w_cur);
                    r_rad[g+1] <= w_rad_in << 2;
                end
            end
        end
    end

    // Three CORDIC pipelines for roll, pitch and yaw.
    t_side                   w_cs;
    logic signed [COR_W-1:0] w_px;
    t_ang                    w_roll_ang, w_pitch_ang, w_yaw_ang;
    assign w_cs = r_side[SQ_STEPS+2];
    assign w_px = COR_W'($signed({1'b0, r_root[SQ_STEPS]}));

    qte_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
        .i_clk (i_clk), .i_en (w_adv),
        .i_y   (COR_W'(w_cs.sr)), .i_x (COR_W'(w_cs.cr)),
        .o_ang (w_roll_ang)
    );
    qte_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
        .i_clk (i_clk), .i_en (w_adv),
        .i_y   (COR_W'(w_cs.sp)), .i_x (w_px),
        .o_ang (w_pitch_ang)
    );
    qte_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
        .i_clk (i_clk), .i_en (w_adv),
        .i_y   (COR_W'(w_cs.sy)), .i_x (COR_W'(w_cs.cy)),
        .o_ang (w_yaw_ang)
    );

    // Saturation flag and pitch sign follow the CORDIC latency.
    logic r_sat_d [0:CORDIC_STEPS];
    logic r_neg_d [0:CORDIC_STEPS];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sat_d[0] <= w_cs.sat;
            r_neg_d[0] <= w_cs.sp[SUM_W-1];
            for (int k = 1; k <= CORDIC_STEPS; k++) begin
                r_sat_d[k] <= r_sat_d[k-1];
                r_neg_d[k] <= r_neg_d[k-1];
            end
        end
    end

    // Output register: rounding, clamping and the saturated pitch.
    logic signed [RND_W-1:0] w_roll_r, w_pitch_r, w_yaw_r;
    assign w_roll_r  = round_clamp(w_roll_ang, ROLL_LIM);
    assign w_pitch_r = round_clamp(w_pitch_ang, PITCH_LIM);
    assign w_yaw_r   = round_clamp(w_yaw_ang, ROLL_LIM);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_roll_angle      <= w_roll_r[12:0];
            o_yaw_angle       <= w_yaw_r[12:0];
            o_pitch_saturated <= r_sat_d[CORDIC_STEPS];
            if (r_sat_d[CORDIC_STEPS]) begin
                o_pitch_angle <= r_neg_d[CORDIC_STEPS] ? -12'sd1440 : 12'sd1440;
            end else begin
                o_pitch_angle <= w_pitch_r[11:0];
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/qte_checker.sv
// ----------------------------------------------------------------------------
// qte_checker
// Port-level checks for the quaternion to Euler angle converter.
// ----------------------------------------------------------------------------
`default_nettype none

`include "quaternion_to_euler_angles_macros.svh"

module qte_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_stall,
    input wire logic               o_valid,
    input wire logic               i_stall,
    input wire logic signed [12:0] o_roll_angle,
    input wire logic signed [11:0] o_pitch_angle,
    input wire logic signed [12:0] o_yaw_angle,
    input wire logic               o_pitch_saturated
);

    // A held result stays offered.
    `QTE_ASSERT_NEXT(a_hold_valid, o_valid && i_stall, o_valid, "result dropped while stalled")

    // The request side only stalls while a result is being held.
    `QTE_ASSERT_IMPL(a_stall_cause, o_stall, o_valid && i_stall, "stall without held result")

    // A saturated pitch is exactly plus or minus ninety degrees.
    `QTE_ASSERT_IMPL(a_sat_pitch, o_valid && o_pitch_saturated,
        o_pitch_angle == 12'sd1440 || o_pitch_angle == -12'sd1440, "bad saturated pitch")

    // Roll and yaw stay within half a turn.
    `QTE_ASSERT_IMPL(a_range, o_valid,
        o_roll_angle <= 13'sd2880 && o_roll_angle >= -13'sd2880 &&
        o_yaw_angle <= 13'sd2880 && o_yaw_angle >= -13'sd2880, "angle out of range")

endmodule

bind quaternion_to_euler_angles qte_checker u_qte_checker (.*);

`default_nettype wire

### bench/quaternion_to_euler_angles_tb.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_tb
// Drives quaternions into the converter, predicts roll, pitch and yaw with a
// bit-exact integer CORDIC model, and compares every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quaternion_to_euler_angles_tb;

    localparam int STEPS     = qte_pkg::CORDIC_STEPS_DEF;
    localparam int FRAC      = qte_pkg::QUAT_FRAC_BITS_DEF;
    localparam int LATENCY   = 2 * FRAC + STEPS + 8;
    localparam int N_RANDOM  = 1600;
    localparam int MAX_CYCLE = 400000;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_quat;

    typedef struct packed {
        logic signed [12:0] roll;
        logic signed [11:0] pitch;
        logic signed [12:0] yaw;
        logic               sat;
    } t_euler;

    // One directed row: the quaternion, and an optional typed-in result.
    typedef struct packed {
        t_quat  q;
        logic   fixed;
        t_euler res;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [15:0] i_quat_w, i_quat_x, i_quat_y, i_quat_z;
    logic               o_valid;
    logic               i_stall;
    logic signed [12:0] o_roll_angle;
    logic signed [11:0] o_pitch_angle;
    logic signed [12:0] o_yaw_angle;
    logic               o_pitch_saturated;

    t_euler angles_due[$];
    int     n_errors = 0;
    int     cycle    = 0;
    bit     hold_long = 0;
    bit     no_idle   = 0;

    quaternion_to_euler_angles uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_quat_w(i_quat_w), .i_quat_x(i_quat_x), .i_quat_y(i_quat_y),
        .i_quat_z(i_quat_z), .o_valid(o_valid), .i_stall(i_stall),
        .o_roll_angle(o_roll_angle), .o_pitch_angle(o_pitch_angle),
        .o_yaw_angle(o_yaw_angle), .o_pitch_saturated(o_pitch_saturated)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // Arithmetic right shift that floors.
    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint atan_const(int i);
        longint tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
            58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
            57, 29, 14, 7, 4, 2, 1, 0};
        return tab[i];
    endfunction

    // Vectoring CORDIC: atan2(y, x) in 2^-16 degree.
    function automatic longint vector_angle(longint y, longint x);
        longint ang, t, nx, ny;
        if (x == 0 && y == 0) return 0;
        ang = 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; ang = qte_pkg::ANG_90;
            end else begin
                t = x; x = -y; y = t; ang = -qte_pkg::ANG_90;
            end
        end
        for (int i = 0; i < STEPS && i < qte_pkg::ATAN_TAB_LEN; i++) begin
            if (y >= 0) begin
                nx = x + shr_floor(y, i);
                ny = y - shr_floor(x, i);
                ang += atan_const(i);
            end else begin
                nx = x - shr_floor(y, i);
                ny = y + shr_floor(x, i);
                ang -= atan_const(i);
            end
            x = nx;
            y = ny;
        end
        return ang;
    endfunction

    function automatic longint to_sixteenths(longint a, longint lim);
        longint r;
        r = (a + 2048) >>> 12;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    // Exact floor square root.
    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic t_euler quat_to_euler(t_quat q);
        longint w, x, y, z, one, sr, cr, sy, cy, sp, mag;
        longint unsigned c;
        t_euler e;
        w = q.w; x = q.x; y = q.y; z = q.z;
        one = longint'(1) << (2 * FRAC);
        sr = 2 * (w * x + y * z);
        cr = one - 2 * (x * x + y * y);
        sy = 2 * (w * z + x * y);
        cy = one - 2 * (y * y + z * z);
        sp = 2 * (w * y - z * x);
        e.roll = 13'(to_sixteenths(vector_angle(sr, cr), qte_pkg::ROLL_LIM));
        e.yaw  = 13'(to_sixteenths(vector_angle(sy, cy), qte_pkg::ROLL_LIM));
        mag = sp < 0 ? -sp : sp;
        if (mag >= one) begin
            e.sat = 1'b1;
            e.pitch = sp < 0 ? -12'sd1440 : 12'sd1440;
        end else begin
            e.sat = 1'b0;
            c = floor_sqrt(longint'(one * one) - mag * mag);
            e.pitch = 12'(to_sixteenths(vector_angle(sp, longint'(c)),
                                        qte_pkg::PITCH_LIM));
        end
        return e;
    endfunction

    function automatic t_quat random_quat();
        t_quat q;
        int mode;
        mode = $urandom_range(0, 9);
        q.w = 16'($urandom()); q.x = 16'($urandom());
        q.y = 16'($urandom()); q.z = 16'($urandom());
        if (mode < 6) begin
            // Halved values: scale components into the 2^14 range.
            q.w = $signed(q.w) >>> 1; q.x = $signed(q.x) >>> 1;
            q.y = $signed(q.y) >>> 1; q.z = $signed(q.z) >>> 1;
        end else if (mode == 6) begin
            // One axis dominant, small others.
            q.x = $signed(q.x) >>> 8; q.y = $signed(q.y) >>> 8;
            q.z = $signed(q.z) >>> 8; q.w = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
        end else if (mode == 7) begin
            // Pitch near the gimbal limits: w equals +/- y, small x and z.
            q.w = 16'($urandom_range(11000, 12000));
            q.y = $urandom_range(0, 1) ? q.w : -q.w;
            q.x = $signed(q.x) >>> 9; q.z = $signed(q.z) >>> 9;
        end
        return q;
    endfunction

    // Sender side: push one request, honoring the stall handshake.
    task automatic send_quat(t_quat q);
        while (!no_idle && $urandom_range(0, 99) < 11) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_quat_w <= q.w; i_quat_x <= q.x; i_quat_y <= q.y; i_quat_z <= q.z;
        angles_due.push_back(quat_to_euler(q));
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Receiver side: random stalls, plus one long hold-off when asked.
    initial begin
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_long) begin
                i_stall <= 1'b1;
                repeat (3 * LATENCY) @(posedge i_clk);
                hold_long = 0;
                i_stall <= 1'b0;
            end else begin
                i_stall <= !no_idle && ($urandom_range(0, 99) < 11);
            end
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_euler exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (angles_due.size() == 0) begin
                $error("unexpected result roll=%0d", o_roll_angle);
                n_errors++;
            end else begin
                exp_r = angles_due.pop_front();
                if (o_roll_angle !== exp_r.roll) begin
                    $error("roll_angle expected %0d actual %0d", exp_r.roll, o_roll_angle);
                    n_errors++;
                end
                if (o_pitch_angle !== exp_r.pitch) begin
                    $error("pitch_angle expected %0d actual %0d",
                           exp_r.pitch, o_pitch_angle);
                    n_errors++;
                end
                if (o_yaw_angle !== exp_r.yaw) begin
                    $error("yaw_angle expected %0d actual %0d", exp_r.yaw, o_yaw_angle);
                    n_errors++;
                end
                if (o_pitch_saturated !== exp_r.sat) begin
                    $error("pitch_saturated expected %0d actual %0d",
                           exp_r.sat, o_pitch_saturated);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog on the cycle count.
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE) begin
            $display("quaternion_to_euler_angles_tb: errors");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial begin
        t_row   rows[$];
        t_row   r;
        t_quat  q;
        t_euler typed;
        i_rst_n  <= 1'b0;
        i_valid  <= 1'b0;
        i_quat_w <= '0; i_quat_x <= '0; i_quat_y <= '0; i_quat_z <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Identity gives all angles zero.
        rows.push_back('{'{16'sd16384, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
                         '{13'sd0, 12'sd0, 13'sd0, 1'b0}});
        // All zero: the cosine terms stay at one, so every angle is zero.
        rows.push_back('{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
                         '{13'sd0, 12'sd0, 13'sd0, 1'b0}});
        // Pitch saturates positive and negative.
        rows.push_back('{'{16'sd16384, 16'sd0, 16'sd16384, 16'sd0}, 1'b0, '0});
        rows.push_back('{'{16'sd16384, 16'sd0, -16'sd16384, 16'sd0}, 1'b0, '0});
        // Half turns about x and z land in the left half plane.
        rows.push_back('{'{16'sd0, 16'sd16384, 16'sd0, 16'sd0}, 1'b0, '0});
        rows.push_back('{'{16'sd0, 16'sd0, 16'sd0, 16'sd16384}, 1'b0, '0});
        rows.push_back('{'{16'sd0, 16'sd0, 16'sd0, -16'sd16384}, 1'b0, '0});
        // 90 degree turns about each axis.
        rows.push_back('{'{16'sd11585, 16'sd11585, 16'sd0, 16'sd0}, 1'b0, '0});
        rows.push_back('{'{16'sd11585, 16'sd0, 16'sd11585, 16'sd0}, 1'b0, '0});
        rows.push_back('{'{16'sd11585, 16'sd0, 16'sd0, -16'sd11585}, 1'b0, '0});
        // Field extremes, non-unit; then a half turn about y and a tiny quaternion.
        rows.push_back('{'{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff}, 1'b0, '0});
        rows.push_back('{'{16'h8000, 16'h8000, 16'h8000, 16'h8000}, 1'b0, '0});
        rows.push_back('{'{16'h8000, 16'h7fff, 16'h8000, 16'h7fff}, 1'b0, '0});
        rows.push_back('{'{16'h7fff, 16'h8000, 16'h0000, 16'hffff}, 1'b0, '0});
        rows.push_back('{'{16'hffff, 16'h0001, 16'h8000, 16'h7fff}, 1'b0, '0});
        rows.push_back('{'{16'sd0, 16'sd0, 16'sd16384, 16'sd0}, 1'b0, '0});
        rows.push_back('{'{16'sd1, 16'sd0, -16'sd1, 16'sd0}, 1'b0, '0});

        foreach (rows[i]) begin
            r = rows[i];
            typed = quat_to_euler(r.q);
            if (r.fixed && typed !== r.res) begin
                $error("directed row %0d: typed result disagrees with prediction", i);
                n_errors++;
            end
            send_quat(r.q);
        end
        i_valid <= 1'b0;

        // Pause the sender until every pending result has drained.
        while (angles_due.size() != 0) @(posedge i_clk);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 200) hold_long = 1;
            no_idle = (n >= 600 && n < 900);
            if (n == 1000) begin
                i_valid <= 1'b0;
                while (angles_due.size() != 0) @(posedge i_clk);
            end
            q = random_quat();
            send_quat(q);
        end
        no_idle = 0;
        i_valid <= 1'b0;

        while (angles_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("quaternion_to_euler_angles_tb: clean");
        end else begin
            $display("quaternion_to_euler_angles_tb: errors");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/qte_pkg.sv
hw/rtl/qte_cordic.sv
hw/rtl/quaternion_to_euler_angles.sv
hw/rtl/qte_checker.sv
bench/quaternion_to_euler_angles_tb.sv
